// ===== sv/fwn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwn_pkg
// Shared types and constants of the framed word FIFO network interface.
// ----------------------------------------------------------------------------
package fwn_pkg;

   // Fixed header layout: magic in bits 63..48, version in bits 47..32.
   localparam logic [15:0] HdrMagic   = 16'h534e;
   localparam logic [15:0] HdrVersion = 16'h0001;

   // The incoming byte count saturates here.
   localparam logic [11:0] CountCap = 12'hfff;

   localparam logic [3:0] AccessBytes = 4'd8;

   // Request type codes on the input channel.
   localparam logic [1:0] ReqWrite = 2'd0;
   localparam logic [1:0] ReqRead  = 2'd1;
   localparam logic [1:0] ReqRxByte = 2'd2;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_BAD_WRITE,
      KIND_WRITE,
      KIND_READ,
      KIND_RX
   } kind_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      kind_type    kind;
      logic        hdr_ok;
      logic        wd_nonzero;
      logic [63:0] write_data;
      logic [7:0]  rx_byte;
      logic        rx_last;
   } item_type;

endpackage
`default_nettype wire

// ===== sv/fwn_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwn_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fwn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 190
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // On a collision the read returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/fwn_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwn_front
// Accepts request beats, classifies them and holds them in a two-entry queue
// until the back end has carried them out.
// ----------------------------------------------------------------------------
module fwn_front import fwn_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 1518,
   parameter int MIN_FRAME_BYTES = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [3:0]  req_access_size,
   input  wire logic [2:0]  req_offset,
   input  wire logic [63:0] req_write_data,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_rx_last,
   output logic             item_valid,
   output item_type         item,
   input  wire logic        item_pop
);

   localparam logic [31:0] MinLen = 32'(MIN_FRAME_BYTES);
   localparam logic [31:0] MaxLen = 32'(MAX_FRAME_BYTES);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   cls;
   logic       access_ok;
   logic       push;

   always_comb begin
      access_ok      = (req_access_size == AccessBytes) && (req_offset == 3'd0);
      cls.hdr_ok     = (req_write_data[63:48] == HdrMagic) &&
                       (req_write_data[47:32] == HdrVersion) &&
                       (req_write_data[31:0] >= MinLen) &&
                       (req_write_data[31:0] <= MaxLen);
      cls.wd_nonzero = (req_write_data != 64'd0);
      cls.write_data = req_write_data;
      cls.rx_byte    = req_rx_byte;
      cls.rx_last    = req_rx_last;
      case (req_type)
         ReqWrite:  cls.kind = access_ok ? KIND_WRITE : KIND_BAD_WRITE;
         ReqRead:   cls.kind = access_ok ? KIND_READ : KIND_NOP;
         ReqRxByte: cls.kind = KIND_RX;
         default:   cls.kind = KIND_NOP;
      endcase
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count exceeds its depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("queue popped while empty");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !item_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a push");

endmodule
`default_nettype wire

// ===== sv/fwn_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwn_back
// Carries out classified requests: transmit framing, receive store fill and
// readout, and the registered result beat.
// ----------------------------------------------------------------------------
module fwn_back import fwn_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 1518,
   parameter int MIN_FRAME_BYTES = 14,
   parameter int STORE_WORDS     = 190
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   input  wire item_type    item,
   output logic             item_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_tx_last,
   output logic             rsp_end_of_run,
   output logic             rsp_rx_ready,
   output logic             rsp_malformed_event,
   output logic             rsp_dropped_event
);

   localparam int AW = $clog2(STORE_WORDS);
   localparam logic [11:0] StoreBytes = 12'(STORE_WORDS * 8);
   localparam logic [11:0] MinCount   = 12'(MIN_FRAME_BYTES);
   localparam logic [11:0] MaxCount   = 12'(MAX_FRAME_BYTES);

   // Transmit state.
   logic [10:0] tx_len_ff, tx_len_in;
   logic [10:0] tx_sent_ff, tx_sent_in;
   logic [2:0]  beat_ff, beat_in;
   // Receive store state.
   logic [10:0] rx_len_ff, rx_len_in;
   logic [AW-1:0] rx_word_ff, rx_word_in;
   logic        hdr_pend_ff, hdr_pend_in;
   logic        in_active_ff, in_active_in;
   logic        in_keep_ff, in_keep_in;
   logic [11:0] in_count_ff, in_count_in;
   logic [63:0] acc_ff, acc_in;
   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] read_data_ff, read_data_in;
   logic        tx_valid_ff, tx_valid_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic        tx_last_ff, tx_last_in;
   logic        eor_ff, eor_in;
   logic        mal_ff, mal_in;
   logic        drop_ff, drop_in;
   logic        rx_ready_ff;

   logic        emit;
   logic [10:0] remaining;
   logic [3:0]  nbytes;
   logic        fin;
   logic        last_frame;
   logic [11:0] cnt_eff;
   logic        keep_eff;
   logic [11:0] cnt_next;
   logic        store_en;
   logic [7:0]  last_idx;
   logic [63:0] ram_rd_data;

   always_comb begin
      emit       = item_valid && (!rsp_valid_ff || rsp_ready);
      remaining  = tx_len_ff - tx_sent_ff;
      nbytes     = (remaining > 11'd8) ? 4'd8 : remaining[3:0];
      last_frame = (remaining <= 11'd8);
      fin        = ({1'b0, beat_ff} + 4'd1) == nbytes;
      cnt_eff    = in_active_ff ? in_count_ff : 12'd0;
      keep_eff   = in_active_ff ? in_keep_ff : (rx_len_ff == 11'd0);
      cnt_next   = (cnt_eff == CountCap) ? cnt_eff : cnt_eff + 12'd1;
      last_idx   = 8'((rx_len_ff - 11'd1) >> 3);
      store_en   = emit && (item.kind == KIND_RX) && keep_eff && (cnt_eff < StoreBytes);
      // A new store word starts cleared, so a short last word reads zero padded.
      acc_in     = ((cnt_eff[2:0] == 3'd0) ? 64'd0 : acc_ff) |
                   (64'(item.rx_byte) << {~cnt_eff[2:0], 3'b000});
   end

   always_comb begin
      tx_len_in    = tx_len_ff;
      tx_sent_in   = tx_sent_ff;
      beat_in      = beat_ff;
      rx_len_in    = rx_len_ff;
      rx_word_in   = rx_word_ff;
      hdr_pend_in  = hdr_pend_ff;
      in_active_in = in_active_ff;
      in_keep_in   = in_keep_ff;
      in_count_in  = in_count_ff;
      item_pop     = 1'b0;
      read_data_in = 64'd0;
      tx_valid_in  = 1'b0;
      tx_byte_in   = 8'd0;
      tx_last_in   = 1'b0;
      eor_in       = 1'b1;
      mal_in       = 1'b0;
      drop_in      = 1'b0;
      if (emit) begin
         case (item.kind)
            KIND_BAD_WRITE: begin
               mal_in   = 1'b1;
               item_pop = 1'b1;
            end
            KIND_WRITE: begin
               if (tx_len_ff == 11'd0) begin
                  item_pop = 1'b1;
                  if (item.hdr_ok) begin
                     tx_len_in  = item.write_data[10:0];
                     tx_sent_in = 11'd0;
                  end else begin
                     mal_in = item.wd_nonzero;
                  end
               end else begin
                  tx_valid_in = 1'b1;
                  tx_byte_in  = item.write_data[{~beat_ff, 3'b000} +: 8];
                  tx_last_in  = fin && last_frame;
                  eor_in      = fin;
                  if (fin) begin
                     item_pop = 1'b1;
                     beat_in  = 3'd0;
                     if (last_frame) begin
                        tx_len_in  = 11'd0;
                        tx_sent_in = 11'd0;
                     end else begin
                        tx_sent_in = tx_sent_ff + 11'd8;
                     end
                  end else begin
                     beat_in = beat_ff + 3'd1;
                  end
               end
            end
            KIND_READ: begin
               item_pop = 1'b1;
               if (rx_len_ff != 11'd0) begin
                  if (hdr_pend_ff) begin
                     hdr_pend_in  = 1'b0;
                     read_data_in = {HdrMagic, HdrVersion, 21'd0, rx_len_ff};
                  end else begin
                     read_data_in = ram_rd_data;
                     if (8'(rx_word_ff) == last_idx) begin
                        rx_len_in  = 11'd0;
                        rx_word_in = '0;
                     end else begin
                        rx_word_in = rx_word_ff + AW'(1);
                     end
                  end
               end
            end
            KIND_RX: begin
               item_pop     = 1'b1;
               in_active_in = 1'b1;
               in_keep_in   = keep_eff;
               in_count_in  = cnt_next;
               if (item.rx_last) begin
                  in_active_in = 1'b0;
                  in_keep_in   = 1'b0;
                  if (keep_eff && (cnt_next >= MinCount) && (cnt_next <= MaxCount) &&
                      (cnt_next <= StoreBytes)) begin
                     rx_len_in   = cnt_next[10:0];
                     rx_word_in  = '0;
                     hdr_pend_in = 1'b1;
                  end else begin
                     drop_in = 1'b1;
                  end
               end
            end
            default: begin
               item_pop = 1'b1;
            end
         endcase
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   // The read address follows the next word position, so a data read in the
   // following cycle already sees its word.
   fwn_ram #(
      .WIDTH(64),
      .DEPTH(STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (cnt_eff[AW+2:3]),
      .wr_data (acc_in),
      .rd_addr (rx_word_in),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_len_ff    <= 11'd0;
         tx_sent_ff   <= 11'd0;
         beat_ff      <= 3'd0;
         rx_len_ff    <= 11'd0;
         rx_word_ff   <= '0;
         hdr_pend_ff  <= 1'b0;
         in_active_ff <= 1'b0;
         in_keep_ff   <= 1'b0;
         in_count_ff  <= 12'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_len_ff    <= tx_len_in;
         tx_sent_ff   <= tx_sent_in;
         beat_ff      <= beat_in;
         rx_len_ff    <= rx_len_in;
         rx_word_ff   <= rx_word_in;
         hdr_pend_ff  <= hdr_pend_in;
         in_active_ff <= in_active_in;
         in_keep_ff   <= in_keep_in;
         in_count_ff  <= in_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         acc_ff <= acc_in;
      end
      if (emit) begin
         read_data_ff <= read_data_in;
         tx_valid_ff  <= tx_valid_in;
         tx_byte_ff   <= tx_byte_in;
         tx_last_ff   <= tx_last_in;
         eor_ff       <= eor_in;
         mal_ff       <= mal_in;
         drop_ff      <= drop_in;
         rx_ready_ff  <= (rx_len_in == 11'd0);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = read_data_ff;
   assign rsp_tx_valid        = tx_valid_ff;
   assign rsp_tx_byte         = tx_byte_ff;
   assign rsp_tx_last         = tx_last_ff;
   assign rsp_end_of_run      = eor_ff;
   assign rsp_rx_ready        = rx_ready_ff;
   assign rsp_malformed_event = mal_ff;
   assign rsp_dropped_event   = drop_ff;

   a_beat_in_data_write: assert property (@(posedge clock) disable iff (reset)
      beat_ff != 3'd0 |-> item_valid && item.kind == KIND_WRITE && tx_len_ff != 11'd0)
      else $error("transmit beat index set outside a data write");

   a_sent_below_len: assert property (@(posedge clock) disable iff (reset)
      tx_len_ff != 11'd0 |-> tx_sent_ff < tx_len_ff)
      else $error("transmit byte count reached the frame length");

   a_empty_store_idle: assert property (@(posedge clock) disable iff (reset)
      rx_len_ff == 11'd0 |-> !hdr_pend_ff && rx_word_ff == '0)
      else $error("readout state left over in an empty store");

   a_word_in_frame: assert property (@(posedge clock) disable iff (reset)
      rx_len_ff != 11'd0 |-> 8'(rx_word_ff) <= last_idx)
      else $error("read position beyond the stored frame");

endmodule
`default_nettype wire

// ===== sv/framed_word_fifo_nic_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// framed_word_fifo_nic_top
// Frame FIFO network interface behind one 8-byte bus register.
// ----------------------------------------------------------------------------
// Each request beat (bus write, bus read or received frame byte) gives one
// result beat, except a transmit data write, which gives one result beat per
// frame byte sent (1 to 8). The back end emits one result beat per cycle
// while a request waits and rsp_ready does not hold the result register; a
// data write stays queued until its last byte is sent, so that byte sequencer
// is what sets the rate. A two-entry queue after classification keeps request
// acceptance going while a result waits on rsp_ready. The receive store is a
// RAM of STORE_WORDS 64-bit words and needs no clearing after reset.
module framed_word_fifo_nic_top import fwn_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 1518,
   parameter int MIN_FRAME_BYTES = 14,
   parameter int STORE_WORDS     = 190
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [3:0]  req_access_size,
   input  wire logic [2:0]  req_offset,
   input  wire logic [63:0] req_write_data,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_rx_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_tx_last,
   output logic             rsp_end_of_run,
   output logic             rsp_rx_ready,
   output logic             rsp_malformed_event,
   output logic             rsp_dropped_event
);

   logic     item_valid;
   item_type item;
   logic     item_pop;

   fwn_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_access_size (req_access_size),
      .req_offset      (req_offset),
      .req_write_data  (req_write_data),
      .req_rx_byte     (req_rx_byte),
      .req_rx_last     (req_rx_last),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   fwn_back #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .MIN_FRAME_BYTES(MIN_FRAME_BYTES),
      .STORE_WORDS    (STORE_WORDS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (item_valid),
      .item                (item),
      .item_pop            (item_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_tx_last         (rsp_tx_last),
      .rsp_end_of_run      (rsp_end_of_run),
      .rsp_rx_ready        (rsp_rx_ready),
      .rsp_malformed_event (rsp_malformed_event),
      .rsp_dropped_event   (rsp_dropped_event)
   );

endmodule
`default_nettype wire

// ===== verif/framed_word_fifo_nic_checker.sv =====
// ----------------------------------------------------------------------------
// framed_word_fifo_nic_checker
// Watches both channels of the frame FIFO interface, keeps its own model of
// the transmit sequencer and the receive store, and compares every response
// beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module framed_word_fifo_nic_checker import fwn_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 1518,
   parameter int MIN_FRAME_BYTES = 14,
   parameter int STORE_WORDS     = 190
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_access_size,
   input  logic [2:0]  req_offset,
   input  logic [63:0] req_write_data,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_read_data,
   input  logic        rsp_tx_valid,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_tx_last,
   input  logic        rsp_end_of_run,
   input  logic        rsp_rx_ready,
   input  logic        rsp_malformed_event,
   input  logic        rsp_dropped_event,
   output int          mismatch_count,
   output int          beats_outstanding
);

   localparam int StoreBytes = STORE_WORDS * 8;

   typedef struct packed {
      logic [63:0] read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic        end_of_run;
      logic        rx_ready;
      logic        malformed_event;
      logic        dropped_event;
   } rsp_beat_type;

   // Transmit side.
   logic [10:0] tx_len;
   logic [11:0] tx_sent;
   // Receive store and read-out position.
   logic [63:0] rx_store [STORE_WORDS];
   logic [11:0] rx_len;
   logic [11:0] rx_pos;
   logic        rx_hdr_pending;
   // Incoming frame.
   logic        in_active;
   logic        in_keep;
   logic [11:0] in_count;

   rsp_beat_type expected_beats[$];
   int           failures = 0;

   initial begin
      mismatch_count    = 0;
      beats_outstanding = 0;
   end

   function automatic logic length_ok(input logic [31:0] n);
      return n >= MIN_FRAME_BYTES && n <= MAX_FRAME_BYTES;
   endfunction

   task automatic queue_beat(input logic [63:0] rd, input logic tv, input logic [7:0] tb,
                             input logic tl, input logic eor, input logic mal,
                             input logic drp);
      rsp_beat_type beat;
      beat.read_data       = rd;
      beat.tx_valid        = tv;
      beat.tx_byte         = tb;
      beat.tx_last         = tl;
      beat.end_of_run      = eor;
      beat.rx_ready        = (rx_len == 0);
      beat.malformed_event = mal;
      beat.dropped_event   = drp;
      expected_beats.push_back(beat);
   endtask

   task automatic predict_responses(input logic [1:0] kind, input logic [3:0] size,
                                    input logic [2:0] off, input logic [63:0] wd,
                                    input logic [7:0] rxb, input logic rxl);
      int          n;
      int          i;
      int          idx;
      int          lane;
      logic        closes;
      logic        drop;
      logic [63:0] word;
      case (kind)
         ReqWrite: begin
            if (size != AccessBytes || off != 3'd0) begin
               queue_beat('0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
            end else if (tx_len == 0) begin
               if (wd[63:48] != HdrMagic || wd[47:32] != HdrVersion ||
                   !length_ok(wd[31:0])) begin
                  queue_beat('0, 1'b0, 8'd0, 1'b0, 1'b1, wd != 64'd0, 1'b0);
               end else begin
                  tx_len  = wd[10:0];
                  tx_sent = '0;
                  queue_beat('0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
               end
            end else begin
               n = int'(tx_len) - int'(tx_sent);
               if (n > 8) n = 8;
               closes = (tx_sent + n >= tx_len);
               if (closes) begin
                  tx_len  = '0;
                  tx_sent = '0;
               end else begin
                  tx_sent = tx_sent + 12'd8;
               end
               // Bytes leave most significant first.
               for (i = 0; i < n; i++) begin
                  queue_beat('0, 1'b1, wd[(7 - i) * 8 +: 8], (i == n - 1) && closes,
                             i == n - 1, 1'b0, 1'b0);
               end
            end
         end
         ReqRead: begin
            word = '0;
            if (size == AccessBytes && off == 3'd0 && rx_len != 0) begin
               if (rx_hdr_pending) begin
                  rx_hdr_pending = 1'b0;
                  word = {HdrMagic, HdrVersion, 20'd0, rx_len};
               end else begin
                  idx = int'(rx_pos >> 3);
                  if (idx < STORE_WORDS) word = rx_store[idx];
                  rx_pos = rx_pos + 12'd8;
                  if (int'(rx_pos) >= ((int'(rx_len) + 7) & ~7)) begin
                     rx_len = '0;
                     rx_pos = '0;
                  end
               end
            end
            queue_beat(word, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
         end
         ReqRxByte: begin
            drop = 1'b0;
            if (!in_active) begin
               in_active = 1'b1;
               in_count  = '0;
               in_keep   = (rx_len == 0);
            end
            if (in_keep && in_count < StoreBytes) begin
               lane = int'(in_count[2:0]);
               if (lane == 0) rx_store[in_count >> 3] = '0;
               rx_store[in_count >> 3][(7 - lane) * 8 +: 8] = rxb;
            end
            if (in_count < CountCap) in_count = in_count + 12'd1;
            if (rxl) begin
               in_active = 1'b0;
               if (in_keep && length_ok(in_count) && in_count <= StoreBytes) begin
                  rx_len         = in_count;
                  rx_pos         = '0;
                  rx_hdr_pending = 1'b1;
               end else begin
                  drop = 1'b1;
               end
               in_keep = 1'b0;
            end
            queue_beat('0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, drop);
         end
         default: begin
            queue_beat('0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic compare_beat();
      rsp_beat_type want;
      if (expected_beats.size() == 0) begin
         $display("%0t: response beat with none expected, read_data %0h tx_byte %0h",
                  $time, rsp_read_data, rsp_tx_byte);
         failures++;
      end else begin
         want = expected_beats.pop_front();
         check_field("read_data", want.read_data, rsp_read_data);
         check_field("tx_valid", 64'(want.tx_valid), 64'(rsp_tx_valid));
         check_field("tx_byte", 64'(want.tx_byte), 64'(rsp_tx_byte));
         check_field("tx_last", 64'(want.tx_last), 64'(rsp_tx_last));
         check_field("end_of_run", 64'(want.end_of_run), 64'(rsp_end_of_run));
         check_field("rx_ready", 64'(want.rx_ready), 64'(rsp_rx_ready));
         check_field("malformed_event", 64'(want.malformed_event),
                     64'(rsp_malformed_event));
         check_field("dropped_event", 64'(want.dropped_event), 64'(rsp_dropped_event));
      end
   endtask

   // A request beat is predicted before the response beat of the same edge is
   // checked, so a response on the edge that accepts its request would still find its expectation.
   always @(posedge clock) begin
      if (reset) begin
         tx_len         = '0;
         tx_sent        = '0;
         foreach (rx_store[i]) rx_store[i] = '0;
         rx_len         = '0;
         rx_pos         = '0;
         rx_hdr_pending = 1'b0;
         in_active      = 1'b0;
         in_keep        = 1'b0;
         in_count       = '0;
         expected_beats.delete();
      end else begin
         if (req_valid && req_ready)
            predict_responses(req_type, req_access_size, req_offset, req_write_data,
                              req_rx_byte, req_rx_last);
         if (rsp_valid && rsp_ready) compare_beat();
      end
      mismatch_count    <= failures;
      beats_outstanding <= expected_beats.size();
   end

endmodule

// ===== verif/framed_word_fifo_nic_top_tb.sv =====
// ----------------------------------------------------------------------------
// framed_word_fifo_nic_top_tb
// Drives bus writes, bus reads and received frame bytes into the frame FIFO
// interface with bursty request traffic and a stalling response side; the
// checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module framed_word_fifo_nic_top_tb import fwn_pkg::*;;

   localparam int MaxFrame    = 1518;
   localparam int MinFrame    = 14;
   localparam int StoreWords  = 190;
   localparam int RandomBeats = 350;
   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 20;

   // Request code with no function; the block answers it with one beat.
   localparam logic [1:0] ReqSpare = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = ReqWrite;
   logic [3:0]  req_access_size = '0;
   logic [2:0]  req_offset = '0;
   logic [63:0] req_write_data = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        req_rx_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_read_data;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        rsp_end_of_run;
   logic        rsp_rx_ready;
   logic        rsp_malformed_event;
   logic        rsp_dropped_event;

   int mismatches;
   int outstanding;
   int req_beats = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_cycle = 0;
   logic stall_on = 1'b1;
   int idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   framed_word_fifo_nic_top #(
      .MAX_FRAME_BYTES(MaxFrame),
      .MIN_FRAME_BYTES(MinFrame),
      .STORE_WORDS(StoreWords)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_access_size(req_access_size),
      .req_offset(req_offset),
      .req_write_data(req_write_data),
      .req_rx_byte(req_rx_byte),
      .req_rx_last(req_rx_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_end_of_run(rsp_end_of_run),
      .rsp_rx_ready(rsp_rx_ready),
      .rsp_malformed_event(rsp_malformed_event),
      .rsp_dropped_event(rsp_dropped_event)
   );

   framed_word_fifo_nic_checker #(
      .MAX_FRAME_BYTES(MaxFrame),
      .MIN_FRAME_BYTES(MinFrame),
      .STORE_WORDS(StoreWords)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_access_size(req_access_size),
      .req_offset(req_offset),
      .req_write_data(req_write_data),
      .req_rx_byte(req_rx_byte),
      .req_rx_last(req_rx_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_end_of_run(rsp_end_of_run),
      .rsp_rx_ready(rsp_rx_ready),
      .rsp_malformed_event(rsp_malformed_event),
      .rsp_dropped_event(rsp_dropped_event),
      .mismatch_count(mismatches),
      .beats_outstanding(outstanding)
   );

   // The response side alternates between stretches with random stalls and
   // stretches where it always takes the beat.
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 300 == 0) stall_on = !stall_on;
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("framed_word_fifo_nic_top_tb: errors");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] header_word(input logic [31:0] len);
      return {HdrMagic, HdrVersion, len};
   endfunction

   // Presents one request beat and returns at the edge that accepts it. The
   // sender works in bursts; a gap may open before the first beat of a burst.
   task automatic send_beat(input logic [1:0] kind, input logic [3:0] size,
                            input logic [2:0] off, input logic [63:0] wd,
                            input logic [7:0] rxb, input logic rxl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_type        <= kind;
      req_access_size <= size;
      req_offset      <= off;
      req_write_data  <= wd;
      req_rx_byte     <= rxb;
      req_rx_last     <= rxl;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_beats++;
   endtask

   task automatic bus_write(input logic [63:0] wd);
      send_beat(ReqWrite, AccessBytes, 3'd0, wd, 8'($urandom), 1'($urandom));
   endtask

   task automatic bus_read();
      send_beat(ReqRead, AccessBytes, 3'd0, rand64(), 8'($urandom), 1'($urandom));
   endtask

   task automatic read_out(input int count);
      repeat (count) bus_read();
   endtask

   // A write or read with a wrong size or a nonzero offset.
   task automatic bad_access(input logic [1:0] kind);
      send_beat(kind, 4'($urandom_range(0, 15)), 3'($urandom_range(1, 7)), rand64(),
                8'($urandom), 1'($urandom));
   endtask

   task automatic noise_beat();
      logic [63:0] wd;
      case ($urandom_range(0, 2))
         0: wd = rand64();
         1: wd = header_word($urandom_range(0, 2 * MaxFrame));
         default: wd = {HdrMagic, 16'($urandom), 32'($urandom)};
      endcase
      send_beat(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                3'($urandom_range(0, 7)), wd, 8'($urandom), 1'($urandom));
   endtask

   task automatic tx_frame(input int len, input bit noisy);
      int k;
      bus_write(header_word(len));
      for (k = 0; k < (len + 7) / 8; k++) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) bad_access(ReqWrite);
            else bus_read();
         end
         bus_write(rand64());
      end
   endtask

   task automatic rx_frame(input int len, input bit noisy);
      int k;
      for (k = 0; k < len; k++) begin
         if (noisy && $urandom_range(0, 15) == 0) bus_read();
         send_beat(ReqRxByte, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                   rand64(), 8'($urandom), k == len - 1);
      end
   endtask

   initial begin
      int len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty read, bad accesses, bad headers, spare code, then the
      // shortest frames each way, a busy store and a short incoming frame.
      bus_read();
      send_beat(ReqWrite, 4'd4, 3'd0, header_word(20), 8'hff, 1'b1);
      send_beat(ReqWrite, AccessBytes, 3'd5, header_word(20), 8'h00, 1'b0);
      send_beat(ReqRead, 4'd15, 3'd0, '1, 8'h00, 1'b0);
      bus_write(64'd0);
      bus_write('1);
      bus_write({16'h534f, HdrVersion, 32'd20});
      bus_write({HdrMagic, 16'h0002, 32'd20});
      bus_write(header_word(MinFrame - 1));
      bus_write(header_word(MaxFrame + 1));
      bus_write(header_word(32'hffff_ffff));
      send_beat(ReqSpare, 4'($urandom), 3'($urandom), rand64(), 8'($urandom),
                1'($urandom));
      bus_write(header_word(MinFrame));
      bus_write(64'h0011_2233_4455_6677);
      bus_write('1);
      rx_frame(MinFrame, 1'b0);
      rx_frame(MinFrame, 1'b0);
      read_out(4);
      rx_frame(MinFrame - 1, 1'b0);
      bus_read();

      while (req_beats < RandomBeats) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(MinFrame, 200)
                                                 : $urandom_range(MinFrame, 40);
               tx_frame(len, 1'b1);
            end
            4, 5, 6: begin
               len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, MinFrame - 1)
                                                 : $urandom_range(MinFrame, 40);
               rx_frame(len, 1'b1);
               // A second frame while the first is still held gets dropped.
               if ($urandom_range(0, 3) == 0) rx_frame($urandom_range(1, 30), 1'b0);
               read_out(len / 8 + $urandom_range(2, 3));
            end
            default: begin
               repeat ($urandom_range(1, 4)) noise_beat();
            end
         endcase
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("framed_word_fifo_nic_top_tb: clean");
      end else begin
         $display("framed_word_fifo_nic_top_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/fwn_pkg.sv
sv/fwn_ram.sv
sv/fwn_front.sv
sv/fwn_back.sv
sv/framed_word_fifo_nic_top.sv
verif/framed_word_fifo_nic_checker.sv
verif/framed_word_fifo_nic_top_tb.sv
